// ===== hdl/tbw_pkg.sv =====
// Shared constants for the triangle barycentric weight pipeline.
`timescale 1ns / 1ps
package tbw_pkg;
   localparam int COORD_WIDTH_DEF = 16;
   localparam int WEIGHT_FRAC_DEF = 16;
   localparam int WEIGHT_WIDTH = 20;
endpackage

// ===== hdl/triangle_barycentric_weights.sv =====
// Fully pipelined barycentric weight unit for a point and a 3D triangle.
`timescale 1ns / 1ps
// One item enters per clock cycle and its result leaves through a restoring
// divider, which resolves one quotient bit per pipeline stage for all three
// weights in parallel, and then a registered output stage. The block
// never stalls: busy stays low and each result is shown for exactly one cycle
// on the rsp_ ports, marked by rsp_valid, so the receiver must take every
// transfer. Weights are signed with WEIGHT_FRAC_BITS fraction bits, rounded to
// nearest with ties away from zero and clamped to the 20-bit range, which sets
// rsp_saturated. A triangle of zero area gives zero weights and rsp_degenerate.
module triangle_barycentric_weights
   import tbw_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_first_z,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_z,
   input  logic signed [COORD_WIDTH-1:0] req_third_x,
   input  logic signed [COORD_WIDTH-1:0] req_third_y,
   input  logic signed [COORD_WIDTH-1:0] req_third_z,
   output logic rsp_valid,
   output logic signed [WEIGHT_WIDTH-1:0] rsp_weight_first,
   output logic signed [WEIGHT_WIDTH-1:0] rsp_weight_second,
   output logic signed [WEIGHT_WIDTH-1:0] rsp_weight_third,
   output logic rsp_degenerate,
   output logic rsp_saturated
);
   localparam int QW = WEIGHT_WIDTH;
   localparam int DW = COORD_WIDTH + 1;
   localparam int XW = 2 * DW + 1;
   localparam int SW = 2 * XW + 2;
   localparam int TW = SW + WEIGHT_FRAC_BITS + QW + 2;
   localparam int LAT = QW + 8;

   typedef struct packed {
      logic [2:0] neg;
      logic [2:0] over;
      logic deg;
   } div_flag_type;

   logic [LAT-1:0] vld_ff;
   logic signed [COORD_WIDTH-1:0] crd_ff [12];
   logic signed [DW-1:0] dif_ff [7][3];
   logic signed [2*DW-1:0] cp_ff [4][6];
   logic signed [XW-1:0] cr_ff [4][3];
   logic signed [2*XW-1:0] dp_ff [4][3];
   logic signed [SW-1:0] sum_ff [4];
   logic [TW-1:0] rem_ff [QW+1][3];
   logic [TW-1:0] rem_in [QW][3];
   logic [QW-1:0] quo_ff [QW+1][3];
   logic [QW-1:0] quo_in [QW][3];
   logic [TW-1:0] dvs_ff [QW+1];
   div_flag_type flg_ff [QW+1];

   // Cross product operands: n = e3 x (c-a), then e1 x d3, e2 x d1, e3 x d2.
   localparam int CU [4] = '{2, 0, 1, 2};
   localparam int CV [4] = '{6, 5, 3, 4};

   // The pipeline never holds off a transfer.
   assign busy = 1'b0;

   // Valid bits travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   // Stage 1: capture the coordinates.
   always_ff @(posedge clock) begin
      crd_ff[0] <= req_point_x;  crd_ff[1] <= req_point_y;  crd_ff[2] <= req_point_z;
      crd_ff[3] <= req_first_x;  crd_ff[4] <= req_first_y;  crd_ff[5] <= req_first_z;
      crd_ff[6] <= req_second_x; crd_ff[7] <= req_second_y; crd_ff[8] <= req_second_z;
      crd_ff[9] <= req_third_x;  crd_ff[10] <= req_third_y; crd_ff[11] <= req_third_z;
   end

   // Stage 2: edge and point differences.
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         dif_ff[0][j] <= DW'(crd_ff[9+j]) - DW'(crd_ff[6+j]);
         dif_ff[1][j] <= DW'(crd_ff[3+j]) - DW'(crd_ff[9+j]);
         dif_ff[2][j] <= DW'(crd_ff[6+j]) - DW'(crd_ff[3+j]);
         dif_ff[3][j] <= DW'(crd_ff[j]) - DW'(crd_ff[3+j]);
         dif_ff[4][j] <= DW'(crd_ff[j]) - DW'(crd_ff[6+j]);
         dif_ff[5][j] <= DW'(crd_ff[j]) - DW'(crd_ff[9+j]);
         dif_ff[6][j] <= DW'(crd_ff[9+j]) - DW'(crd_ff[3+j]);
      end
   end

   // Stage 3: the partial products of the four cross products.
   always_ff @(posedge clock) begin
      for (int x = 0; x < 4; x++) begin
         for (int j = 0; j < 3; j++) begin
            cp_ff[x][2*j] <= (2*DW)'(dif_ff[CU[x]][(j+1)%3])
                           * (2*DW)'(dif_ff[CV[x]][(j+2)%3]);
            cp_ff[x][2*j+1] <= (2*DW)'(dif_ff[CU[x]][(j+2)%3])
                             * (2*DW)'(dif_ff[CV[x]][(j+1)%3]);
         end
      end
   end

   // Stage 4: cross product components.
   always_ff @(posedge clock) begin
      for (int x = 0; x < 4; x++) begin
         for (int j = 0; j < 3; j++) begin
            cr_ff[x][j] <= XW'(cp_ff[x][2*j]) - XW'(cp_ff[x][2*j+1]);
         end
      end
   end

   // Stage 5: products against the normal.
   always_ff @(posedge clock) begin
      for (int x = 0; x < 4; x++) begin
         for (int j = 0; j < 3; j++) begin
            dp_ff[x][j] <= (2*XW)'(cr_ff[x][j]) * (2*XW)'(cr_ff[0][j]);
         end
      end
   end

   // Stage 6: dot product sums; entry 0 is the squared normal length.
   always_ff @(posedge clock) begin
      for (int x = 0; x < 4; x++) begin
         sum_ff[x] <= SW'(dp_ff[x][0]) + SW'(dp_ff[x][1]) + SW'(dp_ff[x][2]);
      end
   end

   // Stage 7: magnitudes with the rounding term, divisor and overflow check.
   always_ff @(posedge clock) begin
      logic [TW-1:0] mag;
      logic [TW-1:0] dvs;
      dvs = TW'(unsigned'(sum_ff[0])) << 1;
      dvs_ff[0] <= dvs;
      flg_ff[0].deg <= (sum_ff[0] == '0);
      for (int l = 0; l < 3; l++) begin
         mag = sum_ff[l+1][SW-1] ? TW'(unsigned'(-sum_ff[l+1]))
                                 : TW'(unsigned'(sum_ff[l+1]));
         mag = (mag << (WEIGHT_FRAC_BITS + 1)) + TW'(unsigned'(sum_ff[0]));
         rem_ff[0][l] <= mag;
         quo_ff[0][l] <= '0;
         flg_ff[0].neg[l] <= sum_ff[l+1][SW-1];
         flg_ff[0].over[l] <= (mag >= (dvs << QW));
      end
   end

   // Restoring divider: one quotient bit per stage for each weight.
   for (genvar k = 0; k < QW; k++) begin : g_div
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            quo_in[k][l] = quo_ff[k][l];
            if (rem_ff[k][l] >= (dvs_ff[k] << (QW - 1 - k))) begin
               rem_in[k][l] = rem_ff[k][l] - (dvs_ff[k] << (QW - 1 - k));
               quo_in[k][l][QW-1-k] = 1'b1;
            end else begin
               rem_in[k][l] = rem_ff[k][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in[k];
         quo_ff[k+1] <= quo_in[k];
         dvs_ff[k+1] <= dvs_ff[k];
         flg_ff[k+1] <= flg_ff[k];
      end
   end

   // Output stage: clamp, apply sign and handle a degenerate triangle.
   always_ff @(posedge clock) begin
      logic [QW-1:0] lim;
      logic [QW-1:0] val;
      logic [QW-1:0] wgt [3];
      logic sat;
      sat = 1'b0;
      for (int l = 0; l < 3; l++) begin
         lim = flg_ff[QW].neg[l] ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - QW'(1));
         val = quo_ff[QW][l];
         if (flg_ff[QW].over[l] || (val > lim)) begin
            val = lim;
            sat = 1'b1;
         end
         wgt[l] = flg_ff[QW].neg[l] ? (QW'(0) - val) : val;
      end
      if (flg_ff[QW].deg) begin
         rsp_weight_first  <= '0;
         rsp_weight_second <= '0;
         rsp_weight_third  <= '0;
         rsp_degenerate    <= 1'b1;
         rsp_saturated     <= 1'b0;
      end else begin
         rsp_weight_first  <= wgt[0];
         rsp_weight_second <= wgt[1];
         rsp_weight_third  <= wgt[2];
         rsp_degenerate    <= 1'b0;
         rsp_saturated     <= sat;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

`ifndef SYNTHESIS
   // Every result follows a transfer in by the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result without a matching transfer in");

   // A degenerate triangle gives zero weights and never a saturation.
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (!rsp_saturated && rsp_weight_first == '0
         && rsp_weight_second == '0 && rsp_weight_third == '0))
      else $error("degenerate result carries weights or saturation");
`endif
endmodule
